>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Clocked on clk_i; the checker that uses them provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hw/rtl/ssmv_pkg.sv
// ----------------------------------------------------------------------------
// ssmv_pkg - shared types and constants
// Sizes, command and status codes, controller states, control structs.
// ----------------------------------------------------------------------------
package ssmv_pkg;

  localparam int MaxDim   = 1024;
  localparam int MaxNz    = 8192;
  localparam int DimAw    = $clog2(MaxDim);      // x / y index
  localparam int PtrAw    = $clog2(MaxDim + 1);  // column pointer index
  localparam int NzAw     = $clog2(MaxNz);       // entry index
  localparam int PtrW     = $clog2(MaxNz + 1);   // pointer value
  localparam int SizeW    = 11;
  localparam int SlotW    = 14;
  localparam int RowW     = 10;
  localparam int ValW     = 32;
  localparam int AccW     = 64;
  localparam int CmdW     = 3;
  localparam int StatW    = 2;

  localparam logic [CmdW-1:0] CMD_LOAD_PTR = 3'd0;
  localparam logic [CmdW-1:0] CMD_LOAD_NZ  = 3'd1;
  localparam logic [CmdW-1:0] CMD_LOAD_X   = 3'd2;
  localparam logic [CmdW-1:0] CMD_COMPUTE  = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ_Y   = 3'd4;

  localparam logic [StatW-1:0] STAT_OK   = 2'd0;
  localparam logic [StatW-1:0] STAT_DONE = 2'd1;
  localparam logic [StatW-1:0] STAT_ERR  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_Y,
    ST_ROW,
    ST_PTR_S,
    ST_PTR_E,
    ST_SCAN,
    ST_CHK,
    ST_XW,
    ST_ACC,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic emit_read;
    logic row_init;
    logic ptr_s;
    logic ptr_e;
    logic col_end;
    logic ent_rd;
    logic x_rd;
    logic k_inc;
    logic mul;
    logic acc;
    logic emit_done;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic in_compute;
    logic in_read_ok;
    logic row_done;
    logic search;
    logic scan_end;
    logic hit;
  } dp_status_t;

endpackage

>>> hw/rtl/ssmv_ctrl.sv
// ----------------------------------------------------------------------------
// ssmv_ctrl - sequencer
// Walks rows, columns and entries; issues datapath commands.
// ----------------------------------------------------------------------------
module ssmv_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ssmv_pkg::dp_status_t  stat_i,
  output ssmv_pkg::dp_cmd_t     cmd_o
);

  ssmv_pkg::state_e state_q, state_d;
  logic             accept;

  assign in_ready_o = (state_q == ssmv_pkg::ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssmv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ssmv_pkg::ST_IDLE: begin
        if (accept && stat_i.in_compute) begin
          state_d = ssmv_pkg::ST_ROW;
        end else if (accept && stat_i.in_read_ok) begin
          state_d = ssmv_pkg::ST_READ_Y;
        end
      end
      ssmv_pkg::ST_READ_Y: state_d = ssmv_pkg::ST_IDLE;
      ssmv_pkg::ST_ROW: begin
        state_d = stat_i.row_done ? ssmv_pkg::ST_DONE : ssmv_pkg::ST_PTR_S;
      end
      ssmv_pkg::ST_PTR_S: state_d = ssmv_pkg::ST_PTR_E;
      ssmv_pkg::ST_PTR_E: state_d = ssmv_pkg::ST_SCAN;
      ssmv_pkg::ST_SCAN: begin
        if (!stat_i.scan_end) begin
          state_d = ssmv_pkg::ST_CHK;
        end else begin
          state_d = stat_i.search ? ssmv_pkg::ST_PTR_S : ssmv_pkg::ST_ROW;
        end
      end
      ssmv_pkg::ST_CHK: state_d = stat_i.hit ? ssmv_pkg::ST_XW : ssmv_pkg::ST_SCAN;
      ssmv_pkg::ST_XW:  state_d = ssmv_pkg::ST_ACC;
      ssmv_pkg::ST_ACC: state_d = stat_i.search ? ssmv_pkg::ST_PTR_S : ssmv_pkg::ST_SCAN;
      ssmv_pkg::ST_DONE: state_d = ssmv_pkg::ST_IDLE;
      default: state_d = ssmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ssmv_pkg::ST_IDLE:   cmd_o.accept    = accept;
      ssmv_pkg::ST_READ_Y: cmd_o.emit_read = 1'b1;
      ssmv_pkg::ST_ROW:    cmd_o.row_init  = !stat_i.row_done;
      ssmv_pkg::ST_PTR_S:  cmd_o.ptr_s     = 1'b1;
      ssmv_pkg::ST_PTR_E:  cmd_o.ptr_e     = 1'b1;
      ssmv_pkg::ST_SCAN: begin
        cmd_o.col_end = stat_i.scan_end;
        cmd_o.ent_rd  = !stat_i.scan_end;
      end
      ssmv_pkg::ST_CHK: begin
        cmd_o.x_rd  = stat_i.hit;
        cmd_o.k_inc = !stat_i.hit;
      end
      ssmv_pkg::ST_XW:   cmd_o.mul       = 1'b1;
      ssmv_pkg::ST_ACC:  cmd_o.acc       = 1'b1;
      ssmv_pkg::ST_DONE: cmd_o.emit_done = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> hw/rtl/ssmv_dp.sv
// ----------------------------------------------------------------------------
// ssmv_dp - datapath
// Matrix, x and y memories, row/column/entry counters, MAC and result reg.
// ----------------------------------------------------------------------------
module ssmv_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssmv_pkg::SizeW-1:0]     cfg_wdata_i,
  input  logic [ssmv_pkg::CmdW-1:0]      in_cmd_i,
  input  logic [ssmv_pkg::SlotW-1:0]     in_slot_i,
  input  logic [ssmv_pkg::RowW-1:0]      in_row_i,
  input  logic [ssmv_pkg::ValW-1:0]      in_val_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ssmv_pkg::StatW-1:0]     out_status_o,
  output logic [ssmv_pkg::AccW-1:0]      out_y_o,
  input  ssmv_pkg::dp_cmd_t              cmd_i,
  output ssmv_pkg::dp_status_t           stat_o
);

  localparam int DimAw = ssmv_pkg::DimAw;
  localparam int PtrAw = ssmv_pkg::PtrAw;
  localparam int NzAw  = ssmv_pkg::NzAw;
  localparam int PtrW  = ssmv_pkg::PtrW;
  localparam int SizeW = ssmv_pkg::SizeW;
  localparam int SlotW = ssmv_pkg::SlotW;
  localparam int RowW  = ssmv_pkg::RowW;
  localparam int ValW  = ssmv_pkg::ValW;
  localparam int AccW  = ssmv_pkg::AccW;
  localparam int EntW  = RowW + ValW;

  // Memories
  logic [PtrW-1:0] ptr_mem [ssmv_pkg::MaxDim+1];
  logic [EntW-1:0] ent_mem [ssmv_pkg::MaxNz];
  logic [ValW-1:0] x_mem   [ssmv_pkg::MaxDim];
  logic [AccW-1:0] y_mem   [ssmv_pkg::MaxDim];

  logic [PtrW-1:0] ptr_rd_q;
  logic [EntW-1:0] ent_rd_q;
  logic [ValW-1:0] x_rd_q;
  logic [AccW-1:0] y_rd_q;

  // Control state
  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] n_q;       // rows written by the last compute
  logic [SizeW-1:0] i_q;
  logic [SizeW-1:0] j_q;
  logic [PtrW-1:0]  k_q;
  logic             search_q;
  logic             rd_hit_q;
  logic             out_valid_q;
  logic [ssmv_pkg::StatW-1:0] out_status_q;
  logic [AccW-1:0]  out_y_q;
  logic [AccW-1:0]  acc_q;
  logic [AccW-1:0]  prod_q;

  logic [SizeW-1:0] n_eff;
  logic [PtrAw-1:0] col;
  logic [PtrAw-1:0] ptr_addr;
  logic [PtrW-1:0]  ptr_clip;
  logic [RowW-1:0]  ent_row;
  logic [ValW-1:0]  ent_val;
  logic [DimAw-1:0] x_addr;
  logic [AccW-1:0]  sum;
  logic             ovf;
  logic [AccW-1:0]  acc_sat;
  logic             next_col;
  logic             last_search;
  logic             ptr_ok, nz_ok, x_ok, rd_ok;
  logic             out_free;

  assign n_eff = (size_q > SizeW'(ssmv_pkg::MaxDim)) ? SizeW'(ssmv_pkg::MaxDim) : size_q;
  assign col      = search_q ? PtrAw'(j_q) : PtrAw'(i_q);
  assign ptr_addr = cmd_i.ptr_s ? col : PtrAw'(col + PtrAw'(1));
  assign ent_row  = ent_rd_q[EntW-1:ValW];
  assign ent_val  = ent_rd_q[ValW-1:0];
  assign x_addr   = search_q ? j_q[DimAw-1:0] : ent_row[DimAw-1:0];

  // Pointer clipped to [0, MaxNz]
  always_comb begin
    if (in_val_i[ValW-1]) begin
      ptr_clip = '0;
    end else if (in_val_i > ValW'(ssmv_pkg::MaxNz)) begin
      ptr_clip = PtrW'(ssmv_pkg::MaxNz);
    end else begin
      ptr_clip = in_val_i[PtrW-1:0];
    end
  end

  assign ptr_ok = in_slot_i <= SlotW'(ssmv_pkg::MaxDim);
  assign nz_ok  = in_slot_i <  SlotW'(ssmv_pkg::MaxNz);
  assign x_ok   = in_slot_i <  SlotW'(ssmv_pkg::MaxDim);
  assign rd_ok  = x_ok;

  // Saturating Q32.32 add
  assign sum     = acc_q + prod_q;
  assign ovf     = (acc_q[AccW-1] == prod_q[AccW-1]) && (sum[AccW-1] != acc_q[AccW-1]);
  assign acc_sat = !ovf ? sum :
                   prod_q[AccW-1] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};

  assign last_search = (j_q + SizeW'(1)) == i_q;
  assign next_col    = search_q && (cmd_i.col_end || cmd_i.acc);
  assign out_free    = !out_valid_q || out_ready_i;

  assign stat_o.out_free   = out_free;
  assign stat_o.in_compute = in_cmd_i == ssmv_pkg::CMD_COMPUTE;
  assign stat_o.in_read_ok = (in_cmd_i == ssmv_pkg::CMD_READ_Y) && rd_ok;
  assign stat_o.row_done   = i_q == n_q;
  assign stat_o.search     = search_q;
  assign stat_o.scan_end   = (k_q >= ptr_rd_q) || (k_q >= PtrW'(ssmv_pkg::MaxNz));
  assign stat_o.hit        = !search_q || (SizeW'(ent_row) == i_q);

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_y_o      = out_y_q;

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_cmd_i == ssmv_pkg::CMD_LOAD_PTR && ptr_ok) begin
      ptr_mem[in_slot_i[PtrAw-1:0]] <= ptr_clip;
    end
    if (cmd_i.ptr_s || cmd_i.ptr_e) begin
      ptr_rd_q <= ptr_mem[ptr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_cmd_i == ssmv_pkg::CMD_LOAD_NZ && nz_ok) begin
      ent_mem[in_slot_i[NzAw-1:0]] <= {in_row_i, in_val_i};
    end
    if (cmd_i.ent_rd) begin
      ent_rd_q <= ent_mem[k_q[NzAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && in_cmd_i == ssmv_pkg::CMD_LOAD_X && x_ok) begin
      x_mem[in_slot_i[DimAw-1:0]] <= in_val_i;
    end
    if (cmd_i.x_rd) begin
      x_rd_q <= x_mem[x_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.col_end && !search_q) begin
      y_mem[i_q[DimAw-1:0]] <= acc_q;
    end
    if (cmd_i.accept) begin
      y_rd_q <= y_mem[in_slot_i[DimAw-1:0]];
    end
  end

  // Product and accumulator
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= AccW'($signed(ent_val) * $signed(x_rd_q));
    end
    if (cmd_i.row_init) begin
      acc_q <= '0;
    end else if (cmd_i.acc) begin
      acc_q <= acc_sat;
    end
  end

  // Counters and config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= SizeW'(1);
      n_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      k_q      <= '0;
      search_q <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (cmd_i.accept && in_cmd_i == ssmv_pkg::CMD_COMPUTE) begin
        n_q <= n_eff;
        i_q <= '0;
      end
      if (cmd_i.accept) begin
        rd_hit_q <= SizeW'(in_slot_i[DimAw-1:0]) < n_q;
      end
      if (cmd_i.row_init) begin
        j_q      <= '0;
        search_q <= i_q != '0;
      end
      if (cmd_i.ptr_e) begin
        k_q <= ptr_rd_q;
      end
      if (cmd_i.k_inc || (cmd_i.acc && !search_q)) begin
        k_q <= k_q + PtrW'(1);
      end
      if (next_col) begin
        j_q <= j_q + SizeW'(1);
        if (last_search) begin
          search_q <= 1'b0;
        end
      end
      if (cmd_i.col_end && !search_q) begin
        i_q <= i_q + SizeW'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_read || cmd_i.emit_done ||
                 (cmd_i.accept && in_cmd_i != ssmv_pkg::CMD_COMPUTE &&
                  !(in_cmd_i == ssmv_pkg::CMD_READ_Y && rd_ok))) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_read) begin
      out_status_q <= ssmv_pkg::STAT_DONE;
      out_y_q      <= rd_hit_q ? y_rd_q : '0;
    end else if (cmd_i.emit_done) begin
      out_status_q <= ssmv_pkg::STAT_DONE;
      out_y_q      <= '0;
    end else if (cmd_i.accept) begin
      out_y_q <= '0;
      priority case (in_cmd_i)
        ssmv_pkg::CMD_LOAD_PTR: out_status_q <= ptr_ok ? ssmv_pkg::STAT_OK : ssmv_pkg::STAT_ERR;
        ssmv_pkg::CMD_LOAD_NZ:  out_status_q <= nz_ok ? ssmv_pkg::STAT_OK : ssmv_pkg::STAT_ERR;
        ssmv_pkg::CMD_LOAD_X:   out_status_q <= x_ok ? ssmv_pkg::STAT_OK : ssmv_pkg::STAT_ERR;
        default:                out_status_q <= ssmv_pkg::STAT_ERR;
      endcase
    end
  end

endmodule

>>> hw/rtl/symmetric_sparse_matvec_lower_csc.sv
// ----------------------------------------------------------------------------
// symmetric_sparse_matvec_lower_csc - symmetric sparse y = A*x, lower CSC
// Loads pointers, entries and x; computes y in Q32.32 with saturation.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Fields (tdata / tuser, low bit first)
// s_axis    in   tdata: slot[13:0] row_number[23:14] operand_value[55:24]
//                tuser: cmd[2:0]
// m_axis    out  tdata: y_value[63:0]   tuser: status[1:0]
// cfg       in   cfg_wdata_i: matrix_size[10:0], written when cfg_we_i
//
// Sequence: a load or a bad command is answered in the cycle after it is
//   taken; a read of y passes through ST_READ_Y first. A compute walks
//   each row i over the columns j<=i: it reads the column's start and end
//   pointers, scans its entries one by one from the one-port entry memory
//   and, on a hit, reads x, multiplies and accumulates.
// Reset: async, active low; y reads as zero until the first compute.
// Stalls: one transfer in flight; s_axis_tready_o drops while busy or while
//   a result waits on m_axis.
// ----------------------------------------------------------------------------
module symmetric_sparse_matvec_lower_csc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,    // matrix_size
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i, // slot, row_number, operand_value
  input  logic [2:0]  s_axis_tuser_i, // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o, // y_value
  output logic [1:0]  m_axis_tuser_o  // status
);

  ssmv_pkg::dp_cmd_t    dp_cmd;
  ssmv_pkg::dp_status_t dp_stat;

  // Sequencer: handshake and row/column walk
  ssmv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  // Datapath: memories, counters, MAC, result register
  ssmv_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_cmd_i     (s_axis_tuser_i),
    .in_slot_i    (s_axis_tdata_i[13:0]),
    .in_row_i     (s_axis_tdata_i[23:14]),
    .in_val_i     (s_axis_tdata_i[55:24]),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_y_o      (m_axis_tdata_o),
    .cmd_i        (dp_cmd),
    .stat_o       (dp_stat)
  );

endmodule

>>> hw/rtl/ssmv_checker.sv
// ----------------------------------------------------------------------------
// ssmv_checker - port-level checks
// Watches the top-level ports; bound to the top level below.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssmv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [2:0]  s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);

  `ASSERT_CLK(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped while stalled")
  `ASSERT_CLK(a_no_take_when_full, m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o, "input taken while result stalled")
  `ASSERT_CLK(a_load_answers, s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i < ssmv_pkg::CMD_COMPUTE |=> m_axis_tvalid_o, "load gave no result next cycle")
  `ASSERT_ALWAYS(a_y_zero, m_axis_tvalid_o && m_axis_tuser_o != ssmv_pkg::STAT_DONE |-> m_axis_tdata_o == 64'd0, "y nonzero without done status")

endmodule

bind symmetric_sparse_matvec_lower_csc ssmv_checker u_ssmv_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
